// ===== rtl/q31_pid_antiwindup_filtered_d_macros.svh =====
// Assertion macros for the checker file of the Q31 PID controller.
// Needs nothing else; include by bare file name.
`ifndef Q31_PID_ANTIWINDUP_FILTERED_D_MACROS_SVH
`define Q31_PID_ANTIWINDUP_FILTERED_D_MACROS_SVH

// Holds at every rising clock edge, reset included.
`define QPID_ASSERT_ALWAYS(label, clk, cond, msg) \
   label: assert property (@(posedge clk) (cond)) else $error(msg);

// Same-cycle implication, off while reset is high.
`define QPID_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off while reset is high.
`define QPID_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/qpid_pkg.sv =====
// Types, register codes and Q31 arithmetic helpers for the PID controller.
// No dependencies; compile first.
package qpid_pkg;

   localparam int DATA_W    = 32;
   localparam int SUM_W     = DATA_W + 2;
   localparam int CSR_IDX_W = 3;

   typedef logic signed [DATA_W-1:0] q31_type;
   typedef logic signed [SUM_W-1:0]  sum_type;

   localparam q31_type Q31_MAX = q31_type'(32'h7FFF_FFFF);
   localparam q31_type Q31_MIN = q31_type'(32'h8000_0000);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PROP_GAIN  = 3'd0,
      CSR_INTEG_GAIN = 3'd1,
      CSR_DERIV_NUM  = 3'd2,
      CSR_DERIV_DEN  = 3'd3,
      CSR_INTEG_MAX  = 3'd4,
      CSR_INTEG_MIN  = 3'd5,
      CSR_OUT_MAX    = 3'd6,
      CSR_OUT_MIN    = 3'd7
   } csr_index_type;

   typedef struct packed {
      q31_type prop_gain;
      q31_type integ_gain;
      q31_type deriv_num;
      q31_type deriv_den;
      q31_type integ_max;
      q31_type integ_min;
      q31_type out_max;
      q31_type out_min;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      prop_gain:  '0,
      integ_gain: '0,
      deriv_num:  '0,
      deriv_den:  '0,
      integ_max:  Q31_MAX,
      integ_min:  Q31_MIN,
      out_max:    Q31_MAX,
      out_min:    Q31_MIN
   };

   function automatic sum_type ext(input q31_type v);
      return sum_type'({{(SUM_W-DATA_W){v[DATA_W-1]}}, v});
   endfunction

   function automatic q31_type sat(input sum_type v);
      q31_type r;
      if (v > ext(Q31_MAX)) begin
         r = Q31_MAX;
      end else if (v < ext(Q31_MIN)) begin
         r = Q31_MIN;
      end else begin
         r = v[DATA_W-1:0];
      end
      return r;
   endfunction

   // (a*b) >> 31 with floor; only -1 * -1 overflows.
   function automatic q31_type qmul(input q31_type a, input q31_type b);
      logic signed [2*DATA_W-1:0] p;
      logic signed [DATA_W:0]     q;
      p = (2*DATA_W)'(a) * (2*DATA_W)'(b);
      q = p[2*DATA_W-1:DATA_W-1];
      return (q > $signed({1'b0, Q31_MAX})) ? Q31_MAX : q[DATA_W-1:0];
   endfunction

endpackage

// ===== rtl/qpid_ifs.sv =====
// Valid/ready channel interfaces: request, response and register write.
// Depends on qpid_pkg.
interface qpid_req_if;
   import qpid_pkg::*;
   logic    valid;
   logic    ready;
   q31_type setpoint;
   q31_type measured;
   modport source (output valid, output setpoint, output measured, input ready);
   modport sink   (input valid, input setpoint, input measured, output ready);
endinterface

interface qpid_rsp_if;
   import qpid_pkg::*;
   logic    valid;
   logic    ready;
   q31_type drive;
   logic    integ_frozen;
   modport source (output valid, output drive, output integ_frozen, input ready);
   modport sink   (input valid, input drive, input integ_frozen, output ready);
endinterface

interface qpid_csr_if;
   import qpid_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   q31_type              data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/qpid_core.sv =====
// PID datapath: P, Tustin I with freeze anti-windup, filtered D, output clamp.
// Holds the loop state; depends on qpid_pkg.
module qpid_core (
   input  logic              clock,
   input  logic              reset,
   input  qpid_pkg::cfg_type cfg,
   input  qpid_pkg::q31_type err,
   input  logic              step,
   output qpid_pkg::q31_type drive_in,
   output logic              frozen_in
);
   import qpid_pkg::*;

   q31_type prev_error_ff, integ_acc_ff, deriv_acc_ff;
   logic    frozen_ff;
   q31_type integ_acc_in, deriv_acc_in;

   q31_type p_term, ig_e, ig_p, dn_e, dn_p, dd_d;
   q31_type i_sum, d_sum, y_sat;
   logic    opposing, in_bounds;

   assign p_term = qmul(cfg.prop_gain, err);
   assign ig_e   = qmul(cfg.integ_gain, err);
   assign ig_p   = qmul(cfg.integ_gain, prev_error_ff);
   assign dn_e   = qmul(cfg.deriv_num, err);
   assign dn_p   = qmul(cfg.deriv_num, prev_error_ff);
   assign dd_d   = qmul(cfg.deriv_den, deriv_acc_ff);

   assign i_sum = sat(ext(ig_e) + ext(ig_p) + ext(integ_acc_ff));
   assign d_sum = sat(ext(dn_e) - ext(dd_d) + ext(dn_p));

   // sign of err * integral, nonzero and negative
   assign opposing  = (err != '0) && (integ_acc_ff != '0)
                      && (err[DATA_W-1] != integ_acc_ff[DATA_W-1]);
   assign in_bounds = (integ_acc_ff < cfg.integ_max) && (integ_acc_ff > cfg.integ_min);

   always_comb begin
      integ_acc_in = integ_acc_ff;
      frozen_in    = frozen_ff;
      if (cfg.integ_gain != '0) begin
         if (frozen_ff) begin
            if (opposing || in_bounds) begin
               frozen_in = 1'b0;
            end
         end else if (i_sum > cfg.integ_max) begin
            integ_acc_in = cfg.integ_max;
            frozen_in    = 1'b1;
         end else if (i_sum < cfg.integ_min) begin
            integ_acc_in = cfg.integ_min;
            frozen_in    = 1'b1;
         end else begin
            integ_acc_in = i_sum;
         end
      end
   end

   assign deriv_acc_in = (cfg.deriv_num != '0) ? d_sum : deriv_acc_ff;

   assign y_sat = sat(ext(p_term) + ext(integ_acc_in) + ext(deriv_acc_in));

   always_comb begin
      if (y_sat > cfg.out_max) begin
         drive_in = cfg.out_max;
      end else if (y_sat < cfg.out_min) begin
         drive_in = cfg.out_min;
      end else begin
         drive_in = y_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_error_ff <= '0;
         integ_acc_ff  <= '0;
         deriv_acc_ff  <= '0;
         frozen_ff     <= 1'b0;
      end else if (step) begin
         prev_error_ff <= err;
         integ_acc_ff  <= integ_acc_in;
         deriv_acc_ff  <= deriv_acc_in;
         frozen_ff     <= frozen_in;
      end
   end

endmodule

// ===== rtl/q31_pid_antiwindup_filtered_d.sv =====
// Channel    Dir  Payload                   Handshake
// req_bus    in   setpoint, measured        valid/ready
// rsp_bus    out  drive, integ_frozen       valid/ready
// csr_bus    in   index, data (8 regs)      valid/ready, ready tied high
// One request per cycle sustained while the response sink keeps ready high.
// Path: input register (error formed on entry), then one pass through the
// six parallel Q31 multipliers and the sum/clamp logic into the output register.
// Synchronous reset clears valids and loop state and sets config registers to defaults.
// A stalled response holds the output register; the input stage keeps taking
// a request while it has room.
// Top level of the Q31 PID controller; depends on qpid_pkg, qpid_ifs, qpid_core.
module q31_pid_antiwindup_filtered_d (
   input  logic clock,
   input  logic reset,
   qpid_req_if.sink   req_bus,
   qpid_rsp_if.source rsp_bus,
   qpid_csr_if.sink   csr_bus
);
   import qpid_pkg::*;

   cfg_type cfg_ff;
   logic    s1_valid_ff;
   q31_type err_ff, err_in;
   logic    out_valid_ff, frozen_ff, frozen_in;
   q31_type drive_ff, drive_in;
   logic    out_ready, step, req_take;

   assign out_ready     = !out_valid_ff || rsp_bus.ready;
   assign step          = s1_valid_ff && out_ready;
   assign req_bus.ready = !s1_valid_ff || out_ready;
   assign req_take      = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   assign err_in = sat(ext(req_bus.setpoint) - ext(req_bus.measured));

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_bus.valid) begin
         unique case (csr_index_type'(csr_bus.index))
            CSR_PROP_GAIN:  cfg_ff.prop_gain  <= csr_bus.data;
            CSR_INTEG_GAIN: cfg_ff.integ_gain <= csr_bus.data;
            CSR_DERIV_NUM:  cfg_ff.deriv_num  <= csr_bus.data;
            CSR_DERIV_DEN:  cfg_ff.deriv_den  <= csr_bus.data;
            CSR_INTEG_MAX:  cfg_ff.integ_max  <= csr_bus.data;
            CSR_INTEG_MIN:  cfg_ff.integ_min  <= csr_bus.data;
            CSR_OUT_MAX:    cfg_ff.out_max    <= csr_bus.data;
            CSR_OUT_MIN:    cfg_ff.out_min    <= csr_bus.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         s1_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         err_ff <= err_in;
      end
   end

   qpid_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .err       (err_ff),
      .step      (step),
      .drive_in  (drive_in),
      .frozen_in (frozen_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_ready) begin
         out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         drive_ff  <= drive_in;
         frozen_ff <= frozen_in;
      end
   end

   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.drive        = drive_ff;
   assign rsp_bus.integ_frozen = frozen_ff;

endmodule

// ===== rtl/qpid_checker.sv =====
// Port-level checks for the Q31 PID controller, bound to the top level.
// Depends on qpid_pkg and the macro header.
`include "q31_pid_antiwindup_filtered_d_macros.svh"

module qpid_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input qpid_pkg::q31_type rsp_drive,
   input logic              rsp_integ_frozen,
   input logic              csr_ready
);
   import qpid_pkg::*;

   `QPID_ASSERT_ALWAYS(a_csr_ready, clock, csr_ready, "register port not ready")
   `QPID_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid, "response after reset")
   `QPID_ASSERT_IMPL(a_ready_flow, clock, reset, rsp_ready, req_ready, "request stalled with sink ready")
   `QPID_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "response dropped")
   `QPID_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_drive) && $stable(rsp_integ_frozen), "stalled response changed")

endmodule

bind q31_pid_antiwindup_filtered_d qpid_checker u_qpid_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_bus.ready),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_drive        (rsp_bus.drive),
   .rsp_integ_frozen (rsp_bus.integ_frozen),
   .csr_ready        (csr_bus.ready)
);

// ===== tb/tb_q31_pid_antiwindup_filtered_d.sv =====
// Self-checking testbench for the Q31 PID controller with anti-windup and filtered derivative.
// A cycle-free controller model predicts drive and freeze flag per request under random flow control.
// Depends on qpid_pkg, qpid_ifs and the q31_pid_antiwindup_filtered_d RTL.
module tb_q31_pid_antiwindup_filtered_d;
   timeunit 1ns;
   timeprecision 1ps;

   import qpid_pkg::*;

   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int PRINT_LIMIT     = 100;
   localparam int RANDOM_PHASES   = 8;
   localparam int ITEMS_PER_PHASE = 125;
   localparam int DRAIN_CYCLES    = 10;

   typedef struct packed {
      q31_type drive;
      logic    frozen;
   } pid_out_type;

   typedef enum int {RX_OPEN, RX_RANDOM, RX_THIRDS, RX_BURSTY} rx_mode_type;

   class pid_loop_tracker_type;
      q31_type     kp, ki, kd_num, kd_den, i_hi, i_lo, y_hi, y_lo;
      q31_type     last_err, i_acc, d_acc;
      bit          frozen;
      pid_out_type drive_q[$];
      int          n_checked, n_errors, n_frozen;

      function new();
         kp       = '0;
         ki       = '0;
         kd_num   = '0;
         kd_den   = '0;
         i_hi     = Q31_MAX;
         i_lo     = Q31_MIN;
         y_hi     = Q31_MAX;
         y_lo     = Q31_MIN;
         last_err = '0;
         i_acc    = '0;
         d_acc    = '0;
         frozen   = 1'b0;
         n_checked = 0;
         n_errors  = 0;
         n_frozen  = 0;
      endfunction

      function void set_reg(csr_index_type idx, q31_type v);
         case (idx)
            CSR_PROP_GAIN:  kp = v;
            CSR_INTEG_GAIN: ki = v;
            CSR_DERIV_NUM:  kd_num = v;
            CSR_DERIV_DEN:  kd_den = v;
            CSR_INTEG_MAX:  i_hi = v;
            CSR_INTEG_MIN:  i_lo = v;
            CSR_OUT_MAX:    y_hi = v;
            CSR_OUT_MIN:    y_lo = v;
            default: ;
         endcase
      endfunction

      static function q31_type clip(longint v);
         if (v > longint'(Q31_MAX)) return Q31_MAX;
         if (v < longint'(Q31_MIN)) return Q31_MIN;
         return q31_type'(v);
      endfunction

      // floor of (a*b)/2^31, only full-scale negative squared overflows
      static function q31_type fmul(q31_type a, q31_type b);
         longint p;
         p = longint'(a) * longint'(b);
         return clip(p >>> 31);
      endfunction

      function void note_sample(q31_type sp, q31_type ms);
         q31_type     err, ival, dval, y;
         pid_out_type want;
         err  = clip(longint'(sp) - longint'(ms));
         ival = i_acc;
         dval = d_acc;
         if (ki != 0) begin
            if (frozen) begin
               if (fmul(err, ival) < 0 || (ival < i_hi && ival > i_lo)) frozen = 1'b0;
            end else begin
               ival = clip(longint'(fmul(ki, err)) + longint'(fmul(ki, last_err))
                           + longint'(ival));
               if (ival > i_hi) begin
                  ival   = i_hi;
                  frozen = 1'b1;
               end else if (ival < i_lo) begin
                  ival   = i_lo;
                  frozen = 1'b1;
               end
            end
         end
         if (kd_num != 0) begin
            dval = clip(longint'(fmul(kd_num, err)) - longint'(fmul(kd_den, d_acc))
                        + longint'(fmul(kd_num, last_err)));
         end
         y = clip(longint'(fmul(kp, err)) + longint'(ival) + longint'(dval));
         if (y > y_hi) y = y_hi;
         else if (y < y_lo) y = y_lo;
         last_err = err;
         i_acc    = ival;
         d_acc    = dval;
         want.drive  = y;
         want.frozen = frozen;
         drive_q.push_back(want);
      endfunction

      task report(string msg);
         n_errors++;
         if (n_errors <= PRINT_LIMIT) $display("[%0t] ERROR: %s", $time, msg);
      endtask

      task check_drive(q31_type drive, logic frz);
         pid_out_type want;
         if (drive_q.size() == 0) begin
            report($sformatf("response with no request pending: drive=%h frozen=%b",
                             drive, frz));
            return;
         end
         want = drive_q.pop_front();
         n_checked++;
         if (frz === 1'b1) n_frozen++;
         if (drive !== want.drive)
            report($sformatf("response %0d: drive %h, predicted %h",
                             n_checked, drive, want.drive));
         if (frz !== want.frozen)
            report($sformatf("response %0d: integ_frozen %b, predicted %b",
                             n_checked, frz, want.frozen));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;

   qpid_req_if req_bus();
   qpid_rsp_if rsp_bus();
   qpid_csr_if csr_bus();

   q31_pid_antiwindup_filtered_d u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   pid_loop_tracker_type tracker = new();

   int          burst_left  = 8;
   int          n_requests  = 0;
   int          n_settings  = 0;
   int          idle_cycles = 0;
   int          stall_left  = 0;
   int          mode_left   = 0;
   int          rx_phase    = 0;
   rx_mode_type rx_mode     = RX_OPEN;
   logic        rx_go;
   q31_type     target      = '0;
   int          err_bias    = 2;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (rsp_bus.valid && rsp_bus.ready)
         tracker.check_drive(rsp_bus.drive, rsp_bus.integ_frozen);
      if (mode_left == 0) begin
         rx_mode   = rx_mode_type'($urandom_range(0, 3));
         mode_left = $urandom_range(40, 300);
      end
      mode_left--;
      if (stall_left > 0) begin
         stall_left--;
         rx_go = 1'b0;
      end else begin
         case (rx_mode)
            RX_OPEN:   rx_go = 1'b1;
            RX_RANDOM: rx_go = ($urandom_range(0, 3) != 0);
            RX_THIRDS: begin
               rx_phase = (rx_phase + 1) % 3;
               rx_go    = (rx_phase == 0);
            end
            default: begin
               if ($urandom_range(0, 19) == 0) begin
                  stall_left = $urandom_range(1, 16);
                  rx_go      = 1'b0;
               end else begin
                  rx_go = 1'b1;
               end
            end
         endcase
      end
      rsp_bus.ready <= rx_go;
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[%0t] ERROR: no handshake for %0d cycles", $time, idle_cycles);
         $display("Test completed with failures");
         $finish;
      end
   end

   task write_reg(input csr_index_type idx, input q31_type val);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= val;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      tracker.set_reg(idx, val);
   endtask

   task csr_done();
      csr_bus.valid <= 1'b0;
      n_settings++;
   endtask

   task send_sample(input q31_type sp, input q31_type ms);
      int gap;
      req_bus.valid    <= 1'b1;
      req_bus.setpoint <= sp;
      req_bus.measured <= ms;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      tracker.note_sample(sp, ms);
      n_requests++;
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task drain();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (tracker.drive_q.size() != 0);
   endtask

   function automatic q31_type any_q31();
      case ($urandom_range(0, 7))
         0:       return Q31_MAX;
         1:       return Q31_MIN;
         2:       return '0;
         3:       return q31_type'($signed($urandom_range(0, 2000)) - 1000);
         default: return q31_type'($urandom());
      endcase
   endfunction

   function automatic q31_type pick_coef();
      case ($urandom_range(0, 9))
         0:          return Q31_MAX;
         1:          return Q31_MIN;
         2:          return '0;
         3, 4, 5:    return q31_type'($signed($urandom()) >>> 6);
         default:    return q31_type'($urandom());
      endcase
   endfunction

   task set_bounds(input csr_index_type hi_idx, input csr_index_type lo_idx);
      q31_type a, b, t;
      a = any_q31();
      b = any_q31();
      if ($urandom_range(0, 9) != 0 && a < b) begin
         t = a;
         a = b;
         b = t;
      end
      write_reg(hi_idx, a);
      write_reg(lo_idx, b);
   endtask

   initial begin
      int      p, i, kind;
      longint  off;
      q31_type sp, ms;

      reset            <= 1'b1;
      req_bus.valid    <= 1'b0;
      req_bus.setpoint <= '0;
      req_bus.measured <= '0;
      csr_bus.valid    <= 1'b0;
      csr_bus.index    <= '0;
      csr_bus.data     <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: integral and derivative both disabled
      send_sample('0, '0);
      send_sample(Q31_MAX, Q31_MIN);
      send_sample(Q31_MIN, Q31_MAX);
      send_sample(Q31_MIN, Q31_MIN);
      drain();

      // full-scale gains, saturating products and integrator clamp/freeze
      write_reg(CSR_PROP_GAIN, Q31_MIN);
      write_reg(CSR_INTEG_GAIN, Q31_MIN);
      write_reg(CSR_DERIV_NUM, Q31_MIN);
      write_reg(CSR_DERIV_DEN, Q31_MAX);
      write_reg(CSR_INTEG_MAX, 32'sh4000_0000);
      write_reg(CSR_INTEG_MIN, 32'shC000_0000);
      write_reg(CSR_OUT_MAX, Q31_MAX);
      write_reg(CSR_OUT_MIN, Q31_MIN);
      csr_done();
      send_sample(Q31_MIN, '0);
      send_sample(Q31_MIN, '0);
      send_sample(Q31_MAX, Q31_MIN);
      send_sample(Q31_MIN, Q31_MAX);
      send_sample('0, '0);
      send_sample(Q31_MAX, Q31_MAX);
      send_sample(32'sd1, '0);
      send_sample('0, 32'sd1);
      send_sample(-32'sd1, '0);
      drain();

      // inverted integral and output bounds
      write_reg(CSR_PROP_GAIN, 32'sh2000_0000);
      write_reg(CSR_INTEG_GAIN, 32'sh1000_0000);
      write_reg(CSR_DERIV_NUM, 32'sh0800_0000);
      write_reg(CSR_DERIV_DEN, Q31_MIN);
      write_reg(CSR_INTEG_MAX, 32'shE000_0000);
      write_reg(CSR_INTEG_MIN, 32'sh2000_0000);
      write_reg(CSR_OUT_MAX, 32'shFFF0_0000);
      write_reg(CSR_OUT_MIN, 32'sh0010_0000);
      csr_done();
      send_sample(32'sh4000_0000, '0);
      send_sample(32'sh4000_0000, '0);
      send_sample(32'sh4000_0000, '0);
      send_sample(32'shC000_0000, '0);
      send_sample(32'shC000_0000, '0);
      send_sample('0, '0);
      drain();

      // integral and derivative off: state must hold
      write_reg(CSR_INTEG_GAIN, '0);
      write_reg(CSR_DERIV_NUM, '0);
      csr_done();
      send_sample(Q31_MAX, '0);
      send_sample(Q31_MIN, '0);
      send_sample('0, '0);
      drain();

      for (p = 0; p < RANDOM_PHASES; p++) begin
         write_reg(CSR_PROP_GAIN, pick_coef());
         write_reg(CSR_INTEG_GAIN, pick_coef());
         write_reg(CSR_DERIV_NUM, pick_coef());
         write_reg(CSR_DERIV_DEN, pick_coef());
         set_bounds(CSR_INTEG_MAX, CSR_INTEG_MIN);
         set_bounds(CSR_OUT_MAX, CSR_OUT_MIN);
         csr_done();
         for (i = 0; i < ITEMS_PER_PHASE; i++) begin
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
               sp = q31_type'($urandom());
               ms = q31_type'($urandom());
            end else if (kind == 1) begin
               sp = any_q31();
               ms = any_q31();
            end else begin
               // tracking: held target, biased small error to wind the integrator
               if ($urandom_range(0, 15) == 0) begin
                  target   = any_q31();
                  err_bias = $urandom_range(0, 2);
               end
               off = longint'($urandom_range(0, 32'h00FF_FFFF)) << $urandom_range(0, 7);
               if (err_bias == 0 || (err_bias == 2 && $urandom_range(0, 1) == 0)) off = -off;
               sp = target;
               ms = pid_loop_tracker_type::clip(longint'(target) - off);
            end
            send_sample(sp, ms);
            if (i == ITEMS_PER_PHASE / 2 && p % 2 == 1) drain();
         end
         drain();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.drive_q.size() != 0)
         tracker.report($sformatf("%0d predicted responses never arrived",
                                  tracker.drive_q.size()));
      $display("Ran %0d requests across %0d register settings; %0d responses checked,",
               n_requests, n_settings + 1, tracker.n_checked);
      $display("%0d of them with the integrator frozen; %0d mismatches.",
               tracker.n_frozen, tracker.n_errors);
      if (tracker.n_errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/qpid_pkg.sv
rtl/qpid_ifs.sv
rtl/qpid_core.sv
rtl/q31_pid_antiwindup_filtered_d.sv
rtl/qpid_checker.sv
tb/tb_q31_pid_antiwindup_filtered_d.sv
